>>> hdl/pnf_pkg.sv
// Shared types and constants of the packed nibble framebuffer.
`timescale 1ns / 1ps
package pnf_pkg;

  localparam int COORD_W = 10;
  localparam int PROD_W  = 20;
  localparam int ROWS_W  = 7;
  localparam int RGB_W   = 16;
  localparam int IN_W    = 72;
  localparam int OUT_W   = 56;

  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_GET   = 3'd1,
    OP_HLINE = 3'd2,
    OP_FILL  = 3'd3,
    OP_PAL   = 3'd4,
    OP_CHUNK = 3'd5,
    OP_PAIR  = 3'd6
  } op_t;

endpackage

>>> hdl/packed_nibble_framebuffer.sv
// Top level: 4-bit palettized framebuffer with dirty-row tracking.
`timescale 1ns / 1ps
// One result per operation. Set, get, line and read pair compute the row
// offset and read the byte store; set and line write back each covered
// pixel and read pair looks up both palette entries. Fill writes every byte
// and then sets every row flag and a palette load sets every row flag, one
// write at a time through the single write port of each memory.
// Next dirty chunk checks one row flag at a time. A result that waits for
// m_tready holds the block for as long. After reset the block clears the
// byte store and sets every row flag before it accepts its first transfer.
// Read pair needs the palette entries it touches to have been loaded.
module packed_nibble_framebuffer #(
  parameter int WIDTH      = 240,
  parameter int HEIGHT     = 240,
  parameter int CHUNK_ROWS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // x, x_end, y, colour, palette_rgb from bit 0 up, zero padded
  input  logic [pnf_pkg::IN_W-1:0]  s_tdata,
  // opcode
  input  logic [2:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // pixel_colour, chunk_start, chunk_rows, left_rgb, right_rgb from bit 0 up
  output logic [pnf_pkg::OUT_W-1:0] m_tdata,
  // status
  output logic                  m_tuser
);
  import pnf_pkg::*;

  localparam int STORE_BYTES = (WIDTH * HEIGHT + 1) / 2;
  localparam int FAW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int RW  = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
  localparam int HALF_W = WIDTH / 2;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_MUL  = 12'b000000000010,
    S_RD   = 12'b000000000100,
    S_WR   = 12'b000000001000,
    S_GET  = 12'b000000010000,
    S_PAIR = 12'b000000100000,
    S_PALR = 12'b000001000000,
    S_SCRD = 12'b000010000000,
    S_SCCK = 12'b000100000000,
    S_FILL = 12'b001000000000,
    S_DSET = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_t;

  state_t state;
  op_t    op;
  logic   init;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] x_hi;
  logic [COORD_W-1:0] cur_y;
  logic [PROD_W-1:0]  prod;
  logic [FAW:0]       fcnt;
  logic [7:0]         fill_byte;
  logic [COORD_W:0]   row;

  logic               res_status;
  logic [3:0]         res_pix;
  logic [COORD_W-1:0] res_cstart;
  logic [ROWS_W-1:0]  res_crows;
  logic [RGB_W-1:0]   res_l;
  logic [RGB_W-1:0]   res_r;

  logic [RGB_W-1:0] pal [16];
  logic [RGB_W-1:0] pal_l;
  logic [RGB_W-1:0] pal_r;

  logic           fr_we;
  logic [FAW-1:0] fr_addr;
  logic [7:0]     fr_wdata;
  logic [7:0]     fr_rdata;
  logic           fl_we;
  logic [RW-1:0]  fl_addr;
  logic           fl_wdata;
  logic           fl_rdata;

  logic signed [15:0] in_x, in_xe, in_y;
  logic [3:0]         in_c;
  logic [RGB_W-1:0]   in_rgb;
  logic signed [16:0] line_a, line_b, width_s;
  logic [COORD_W-1:0] line_lo, line_hi;
  logic               y_ok, x_ok, pair_ok, line_ok, accept, out_load, in_hline;
  logic [PROD_W-1:0]  pix_lin, pair_lin;

  assign in_x    = s_tdata[15:0];
  assign in_xe   = s_tdata[31:16];
  assign in_y    = s_tdata[47:32];
  assign in_c    = s_tdata[51:48];
  assign in_rgb  = s_tdata[67:52];
  assign width_s = 17'(WIDTH);

  assign y_ok    = !in_y[15] && (in_y < 16'(HEIGHT));
  assign x_ok    = !in_x[15] && (in_x < 16'(WIDTH));
  assign pair_ok = !in_x[15] && (in_x < 16'(HALF_W));
  always_comb begin
    if (in_x > in_xe) begin
      line_a = 17'(in_xe);
      line_b = 17'(in_x);
    end else begin
      line_a = 17'(in_x);
      line_b = 17'(in_xe);
    end
  end
  assign line_ok = y_ok && !line_b[16] && (line_a < width_s);
  assign line_lo = line_a[16] ? '0 : line_a[COORD_W-1:0];
  assign line_hi = (line_b >= width_s) ? COORD_W'(WIDTH - 1) : line_b[COORD_W-1:0];
  assign in_hline = (op_t'(s_tuser) == OP_HLINE);

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  assign pix_lin  = prod + PROD_W'(cur_x);
  assign pair_lin = (prod >> 1) + PROD_W'(cur_x);

  always_comb begin
    fr_we    = 1'b0;
    fr_addr  = fcnt[FAW-1:0];
    fr_wdata = fill_byte;
    if (state == S_FILL) begin
      fr_we = 1'b1;
    end else if (state == S_RD) begin
      fr_addr = (op == OP_PAIR) ? pair_lin[FAW-1:0] : pix_lin[FAW:1];
    end else if (state == S_WR) begin
      fr_we    = 1'b1;
      fr_addr  = pix_lin[FAW:1];
      fr_wdata = cur_x[0] ? {fill_byte[3:0], fr_rdata[3:0]}
                          : {fr_rdata[7:4], fill_byte[3:0]};
    end
  end

  always_comb begin
    fl_we    = 1'b0;
    fl_addr  = row[RW-1:0];
    fl_wdata = 1'b1;
    if (state == S_DSET) begin
      fl_we = 1'b1;
    end else if (state == S_WR) begin
      fl_we   = 1'b1;
      fl_addr = cur_y[RW-1:0];
    end else if (state == S_SCCK) begin
      fl_we    = fl_rdata;
      fl_wdata = 1'b0;
    end
  end

  pnf_ram #(.DW(8), .DEPTH(STORE_BYTES), .AW(FAW)) u_frame (
    .clk(clk), .we(fr_we), .addr(fr_addr), .wdata(fr_wdata), .rdata(fr_rdata)
  );

  pnf_ram #(.DW(1), .DEPTH(HEIGHT), .AW(RW)) u_flags (
    .clk(clk), .we(fl_we), .addr(fl_addr), .wdata(fl_wdata), .rdata(fl_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept && (op_t'(s_tuser) == OP_PAL)) begin
      pal[in_c] <= in_rgb;
    end
    if (state == S_PAIR) begin
      pal_l <= pal[fr_rdata[3:0]];
      pal_r <= pal[fr_rdata[7:4]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      init      <= 1'b1;
      fcnt      <= '0;
      fill_byte <= '0;
      row       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op         <= op_t'(s_tuser);
            init       <= 1'b0;
            res_pix    <= '0;
            res_cstart <= '0;
            res_crows  <= '0;
            res_l      <= '0;
            res_r      <= '0;
            cur_y      <= in_y[COORD_W-1:0];
            cur_x      <= in_hline ? line_lo : in_x[COORD_W-1:0];
            x_hi       <= in_hline ? line_hi : in_x[COORD_W-1:0];
            fill_byte  <= {in_c, in_c};
            fcnt       <= '0;
            row        <= '0;
            unique case (op_t'(s_tuser))
              OP_SET, OP_GET: begin
                res_status <= !(y_ok && x_ok);
                state      <= (y_ok && x_ok) ? S_MUL : S_OUT;
              end
              OP_HLINE: begin
                res_status <= !line_ok;
                state      <= line_ok ? S_MUL : S_OUT;
              end
              OP_FILL: begin
                res_status <= 1'b0;
                state      <= S_FILL;
              end
              OP_PAL: begin
                res_status <= 1'b0;
                state      <= S_DSET;
              end
              OP_CHUNK: begin
                res_status <= 1'b0;
                state      <= S_SCRD;
              end
              OP_PAIR: begin
                res_status <= !(y_ok && pair_ok);
                state      <= (y_ok && pair_ok) ? S_MUL : S_OUT;
              end
              default: begin
                res_status <= 1'b1;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(cur_y) * PROD_W'(WIDTH);
          state <= S_RD;
        end
        S_RD: begin
          priority if (op == OP_GET) state <= S_GET;
          else if (op == OP_PAIR) state <= S_PAIR;
          else state <= S_WR;
        end
        S_WR: begin
          if (cur_x == x_hi) begin
            state <= S_OUT;
          end else begin
            cur_x <= cur_x + 1'b1;
            state <= S_RD;
          end
        end
        S_GET: begin
          res_pix <= cur_x[0] ? fr_rdata[7:4] : fr_rdata[3:0];
          state   <= S_OUT;
        end
        S_PAIR: state <= S_PALR;
        S_PALR: begin
          res_l <= pal_l;
          res_r <= pal_r;
          state <= S_OUT;
        end
        S_SCRD: state <= S_SCCK;
        S_SCCK: begin
          if (fl_rdata) begin
            if (res_crows == '0) res_cstart <= row[COORD_W-1:0];
            res_crows <= res_crows + 1'b1;
            if ((res_crows + 1'b1 == ROWS_W'(CHUNK_ROWS)) ||
                (row + 1'b1 == (COORD_W + 1)'(HEIGHT))) begin
              state <= S_OUT;
            end else begin
              row   <= row + 1'b1;
              state <= S_SCRD;
            end
          end else if ((res_crows != '0) ||
                       (row + 1'b1 == (COORD_W + 1)'(HEIGHT))) begin
            state <= S_OUT;
          end else begin
            row   <= row + 1'b1;
            state <= S_SCRD;
          end
        end
        S_FILL: begin
          fcnt <= fcnt + 1'b1;
          if (fcnt == (FAW + 1)'(STORE_BYTES - 1)) begin
            row   <= '0;
            state <= S_DSET;
          end
        end
        S_DSET: begin
          row <= row + 1'b1;
          if (row == (COORD_W + 1)'(HEIGHT - 1)) begin
            state <= init ? S_IDLE : S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {3'b000, res_r, res_l, res_crows, res_cstart, res_pix};
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("accepted transfer did not start work");

  a_frame_write_state: assert property (@(posedge clk) disable iff (rst)
    fr_we |-> (state == S_FILL || state == S_WR))
    else $error("byte store written outside fill or modify");

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result overwrote a pending transfer");

  a_chunk_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[20:14] <= ROWS_W'(CHUNK_ROWS)))
    else $error("chunk longer than allowed");

endmodule

>>> hdl/pnf_ram.sv
// Single-port synchronous memory with registered read data.
`timescale 1ns / 1ps
module pnf_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 28800,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> bench/packed_nibble_framebuffer_test.sv
// Self-checking testbench for the packed nibble framebuffer.
`timescale 1ns / 1ps
module packed_nibble_framebuffer_test;
  import pnf_pkg::*;

  localparam int W = 240;
  localparam int H = 240;
  localparam int CHUNK = 8;
  localparam int BYTES = (W * H + 1) / 2;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam longint CYCLE_LIMIT = 64'd12_000_000;

  typedef struct packed {
    logic        status;
    logic [3:0]  pixel_colour;
    logic [9:0]  chunk_start;
    logic [6:0]  chunk_rows;
    logic [15:0] left_rgb;
    logic [15:0] right_rgb;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;

  logic [7:0] frame_model [BYTES];
  logic dirty_model [H];
  logic [15:0] palette_model [16];
  result_t expected_results [$];
  int mismatches = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit no_gaps = 1'b0;

  packed_nibble_framebuffer #(.WIDTH(W), .HEIGHT(H), .CHUNK_ROWS(CHUNK)) dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  function automatic int gap_len();
    if (no_gaps) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3) == 0 ? $urandom_range(2, 1) : 0;
  endfunction

  function automatic void write_nibble(int x, int y, logic [3:0] c);
    int p;
    p = y * W + x;
    if (x & 1) frame_model[p >> 1][7:4] = c;
    else frame_model[p >> 1][3:0] = c;
  endfunction

  function automatic result_t framebuffer_predict(logic [2:0] op, int x, int xe, int y,
                                                  logic [3:0] c, logic [15:0] rgb);
    result_t r;
    int a, b, n;
    bit y_ok;
    logic [7:0] v;
    r = '0;
    y_ok = (y >= 0 && y < H);
    case (op)
      OP_SET: begin
        if (y_ok && x >= 0 && x < W) begin
          write_nibble(x, y, c);
          dirty_model[y] = 1'b1;
        end else r.status = 1'b1;
      end
      OP_GET: begin
        if (y_ok && x >= 0 && x < W) begin
          v = frame_model[(y * W + x) >> 1];
          r.pixel_colour = (x & 1) ? v[7:4] : v[3:0];
        end else r.status = 1'b1;
      end
      OP_HLINE: begin
        a = x < xe ? x : xe;
        b = x < xe ? xe : x;
        if (!y_ok || b < 0 || a >= W) r.status = 1'b1;
        else begin
          if (a < 0) a = 0;
          if (b >= W) b = W - 1;
          for (int i = a; i <= b; i++) write_nibble(i, y, c);
          dirty_model[y] = 1'b1;
        end
      end
      OP_FILL: begin
        foreach (frame_model[i]) frame_model[i] = {c, c};
        foreach (dirty_model[i]) dirty_model[i] = 1'b1;
      end
      OP_PAL: begin
        palette_model[c] = rgb;
        foreach (dirty_model[i]) dirty_model[i] = 1'b1;
      end
      OP_CHUNK: begin
        a = 0;
        n = 0;
        while (a < H && !dirty_model[a]) a++;
        if (a < H) begin
          r.chunk_start = 10'(a);
          while (a < H && dirty_model[a] && n < CHUNK) begin
            dirty_model[a] = 1'b0;
            a++;
            n++;
          end
          r.chunk_rows = 7'(n);
        end
      end
      OP_PAIR: begin
        if (y_ok && x >= 0 && x < (W >> 1)) begin
          v = frame_model[((y * W) >> 1) + x];
          r.left_rgb = palette_model[v[3:0]];
          r.right_rgb = palette_model[v[7:4]];
        end else r.status = 1'b1;
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  task automatic send_op(input logic [2:0] op, input int x, input int xe, input int y,
                         input logic [3:0] c, input logic [15:0] rgb);
    logic [15:0] xs, xes, ys;
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    xs = x[15:0];
    xes = xe[15:0];
    ys = y[15:0];
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'b0000, rgb, c, ys, xes, xs};
    expected_results.push_back(framebuffer_predict(op, $signed(xs), $signed(xes),
                                                   $signed(ys), c, rgb));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tuser;
      {got.right_rgb, got.left_rgb, got.chunk_rows, got.chunk_start,
       got.pixel_colour} = m_tdata[52:0];
      if (expected_results.size() == 0) report("unexpected result", 0, 0);
      else begin
        want = expected_results.pop_front();
        if (got.status != want.status) report("status", got.status, want.status);
        if (got.pixel_colour != want.pixel_colour)
          report("pixel_colour", got.pixel_colour, want.pixel_colour);
        if (got.chunk_start != want.chunk_start)
          report("chunk_start", got.chunk_start, want.chunk_start);
        if (got.chunk_rows != want.chunk_rows)
          report("chunk_rows", got.chunk_rows, want.chunk_rows);
        if (got.left_rgb != want.left_rgb) report("left_rgb", got.left_rgb, want.left_rgb);
        if (got.right_rgb != want.right_rgb)
          report("right_rgb", got.right_rgb, want.right_rgb);
      end
    end
  end

  always @(posedge clk) begin
    int g;
    if (rst || hold_off) m_tready <= 1'b0;
    else if (no_gaps) m_tready <= 1'b1;
    else begin
      g = $urandom_range(9);
      m_tready <= (g > 2) || (g == 0 && $urandom_range(1));
    end
  end

  function automatic int rand_coord();
    case ($urandom_range(9))
      0: return $signed(16'($urandom));
      1: return -int'($urandom_range(3, 1));
      2: return $urandom_range(260, 236);
      default: return $urandom_range(W - 1);
    endcase
  endfunction

  function automatic logic [2:0] rand_op();
    int k;
    k = $urandom_range(99);
    if (k < 25) return OP_SET;
    if (k < 45) return OP_GET;
    if (k < 58) return OP_HLINE;
    if (k < 60) return OP_FILL;
    if (k < 65) return OP_PAL;
    if (k < 78) return OP_CHUNK;
    if (k < 97) return OP_PAIR;
    return OP_UNUSED;
  endfunction

  task automatic load_palette();
    for (int i = 0; i < 16; i++) send_op(OP_PAL, 0, 0, 0, 4'(i), 16'($urandom));
  endtask

  task automatic test_directed();
    send_op(OP_GET, 0, 0, 0, 0, 0);
    send_op(OP_CHUNK, 0, 0, 0, 0, 0);
    send_op(OP_SET, 0, 0, 0, 4'hF, 16'hFFFF);
    send_op(OP_SET, W - 1, 0, H - 1, 4'hA, 0);
    send_op(OP_SET, -1, 0, 5, 4'h3, 0);
    send_op(OP_SET, 5, 0, -32768, 4'h3, 0);
    send_op(OP_GET, W, 0, 0, 0, 0);
    send_op(OP_GET, W - 1, 0, H - 1, 0, 0);
    send_op(OP_HLINE, 32767, -32768, 10, 4'h5, 0);
    send_op(OP_HLINE, 20, 3, 11, 4'h6, 0);
    send_op(OP_HLINE, -5, -1, 12, 4'h7, 0);
    send_op(OP_HLINE, W, 300, 12, 4'h7, 0);
    send_op(OP_HLINE, 0, 5, H, 4'h7, 0);
    send_op(OP_PAIR, W / 2 - 1, 0, H - 1, 0, 0);
    send_op(OP_PAIR, W / 2, 0, 0, 0, 0);
    send_op(OP_PAIR, -1, 0, 0, 0, 0);
    send_op(OP_UNUSED, 0, 0, 0, 0, 0);
    for (int i = 0; i < 32; i++) send_op(OP_CHUNK, 0, 0, 0, 0, 0);
    send_op(OP_FILL, 0, 0, 0, 4'h9, 0);
    send_op(OP_GET, 7, 0, 100, 0, 0);
    send_op(OP_CHUNK, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random(input int count);
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      op = rand_op();
      send_op(op, rand_coord(), rand_coord(), rand_coord(), 4'($urandom),
              16'($urandom));
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        no_gaps = 1'b1;
        for (int i = 0; i < 20; i++) send_op(OP_GET, i, 0, i, 0, 0);
        no_gaps = 1'b0;
      end
    join
  endtask

  task automatic test_full_speed();
    no_gaps = 1'b1;
    test_random(60);
    no_gaps = 1'b0;
  endtask

  initial begin
    foreach (frame_model[i]) frame_model[i] = '0;
    foreach (dirty_model[i]) dirty_model[i] = 1'b1;
    foreach (palette_model[i]) palette_model[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    load_palette();
    test_directed();
    test_backpressure();
    test_random(780);
    test_full_speed();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
hdl/pnf_pkg.sv
hdl/pnf_ram.sv
hdl/packed_nibble_framebuffer.sv
bench/packed_nibble_framebuffer_test.sv
